FILE: src/rpc_frame_deframer_assert.svh
// ----------------------------------------------------------------------------
// rpc_frame_deframer assertion macros
// Shorthand for the concurrent checks used inside the deframer modules.
// Each macro expects clk and rst_n (synchronous, active low) in scope.
// ----------------------------------------------------------------------------
`ifndef RPC_FRAME_DEFRAMER_ASSERT_SVH
`define RPC_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication.
`define RPCFD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rpcfd assertion failed");

// Next-cycle implication.
`define RPCFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rpcfd assertion failed");

`endif

FILE: src/rpcfd_pkg.sv
// ----------------------------------------------------------------------------
// rpcfd_pkg
// Shared constants, codes and types of the RPC frame deframer.
// ----------------------------------------------------------------------------
package rpcfd_pkg;

  // Header layout: magic, 16-bit control length, 32-bit payload length
  localparam int MAGIC_LEN  = 7;
  localparam int HEADER_LEN = MAGIC_LEN + 6;
  localparam int HDR_IDX_W  = 4;

  typedef logic [HDR_IDX_W-1:0] hdr_idx_t;

  localparam hdr_idx_t MAGIC_END_IDX = hdr_idx_t'(MAGIC_LEN);
  localparam hdr_idx_t CL_B0_IDX     = hdr_idx_t'(MAGIC_LEN);
  localparam hdr_idx_t CL_B1_IDX     = hdr_idx_t'(MAGIC_LEN + 1);
  localparam hdr_idx_t PL_B0_IDX     = hdr_idx_t'(MAGIC_LEN + 2);
  localparam hdr_idx_t PL_B1_IDX     = hdr_idx_t'(MAGIC_LEN + 3);
  localparam hdr_idx_t PL_B2_IDX     = hdr_idx_t'(MAGIC_LEN + 4);
  localparam hdr_idx_t PL_B3_IDX     = hdr_idx_t'(MAGIC_LEN + 5);
  localparam hdr_idx_t HDR_LAST_IDX  = hdr_idx_t'(HEADER_LEN - 1);

  typedef logic [1:0] byte_class_t;
  localparam byte_class_t CLS_HEADER  = 2'd0;
  localparam byte_class_t CLS_CONTROL = 2'd1;
  localparam byte_class_t CLS_PAYLOAD = 2'd2;
  localparam byte_class_t CLS_DISCARD = 2'd3;

  typedef logic [1:0] err_code_t;
  localparam err_code_t ERR_NONE      = 2'd0;
  localparam err_code_t ERR_BAD_MAGIC = 2'd1;
  localparam err_code_t ERR_ZERO_CTRL = 2'd2;

  typedef struct packed {
    logic [7:0]  out_byte;
    byte_class_t byte_class;
    logic        control_last;
    logic        message_last;
    err_code_t   error_code;
  } result_t;

  // "RPC0.1" followed by zero bytes
  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h52;
      3'd1:    b = 8'h50;
      3'd2:    b = 8'h43;
      3'd3:    b = 8'h30;
      3'd4:    b = 8'h2E;
      3'd5:    b = 8'h31;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: src/rpcfd_parser.sv
// ----------------------------------------------------------------------------
// rpcfd_parser
// Frame parse state and the per-byte classification logic.
// ----------------------------------------------------------------------------
`include "rpc_frame_deframer_assert.svh"

module rpcfd_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,       // byte in the input register moves on
  input  logic [7:0]         data_byte,
  output rpcfd_pkg::result_t res
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_CONTROL,
    PH_PAYLOAD,
    PH_FATAL
  } phase_t;

  phase_t              phase_r,  phase_nxt;
  rpcfd_pkg::hdr_idx_t idx_r,    idx_nxt;
  logic                mism_r,   mism_nxt;
  logic [15:0]         cl_r,     cl_nxt;
  logic [31:0]         pl_r,     pl_nxt;
  logic [31:0]         rem_r,    rem_nxt;

  always_comb begin
    phase_nxt        = phase_r;
    idx_nxt          = idx_r;
    mism_nxt         = mism_r;
    cl_nxt           = cl_r;
    pl_nxt           = pl_r;
    rem_nxt          = rem_r;
    res.out_byte     = data_byte;
    res.byte_class   = rpcfd_pkg::CLS_HEADER;
    res.control_last = 1'b0;
    res.message_last = 1'b0;
    res.error_code   = rpcfd_pkg::ERR_NONE;

    case (phase_r)
      PH_HEADER: begin
        if (idx_r < rpcfd_pkg::MAGIC_END_IDX) begin
          if (data_byte != rpcfd_pkg::magic_byte(idx_r[2:0])) begin
            mism_nxt = 1'b1;
          end
        end
        if (idx_r == rpcfd_pkg::CL_B0_IDX) cl_nxt[7:0]   = data_byte;
        if (idx_r == rpcfd_pkg::CL_B1_IDX) cl_nxt[15:8]  = data_byte;
        if (idx_r == rpcfd_pkg::PL_B0_IDX) pl_nxt[7:0]   = data_byte;
        if (idx_r == rpcfd_pkg::PL_B1_IDX) pl_nxt[15:8]  = data_byte;
        if (idx_r == rpcfd_pkg::PL_B2_IDX) pl_nxt[23:16] = data_byte;
        if (idx_r == rpcfd_pkg::PL_B3_IDX) pl_nxt[31:24] = data_byte;

        if (idx_r >= rpcfd_pkg::HDR_LAST_IDX) begin
          // bad magic wins over a zero control length
          if (mism_r) begin
            res.error_code = rpcfd_pkg::ERR_BAD_MAGIC;
            phase_nxt      = PH_FATAL;
          end else if (cl_r == 16'd0) begin
            res.error_code = rpcfd_pkg::ERR_ZERO_CTRL;
            phase_nxt      = PH_FATAL;
          end else begin
            phase_nxt = PH_CONTROL;
            rem_nxt   = {16'd0, cl_r};
          end
          idx_nxt  = '0;
          mism_nxt = 1'b0;
        end else begin
          idx_nxt = idx_r + rpcfd_pkg::hdr_idx_t'(1);
        end
      end
      PH_CONTROL: begin
        res.byte_class = rpcfd_pkg::CLS_CONTROL;
        if (rem_r <= 32'd1) begin
          res.control_last = 1'b1;
          if (pl_r == 32'd0) begin
            res.message_last = 1'b1;
            rem_nxt          = '0;
            phase_nxt        = PH_HEADER;
            idx_nxt          = '0;
            mism_nxt         = 1'b0;
          end else begin
            rem_nxt   = pl_r;
            phase_nxt = PH_PAYLOAD;
          end
        end else begin
          rem_nxt = rem_r - 32'd1;
        end
      end
      PH_PAYLOAD: begin
        res.byte_class = rpcfd_pkg::CLS_PAYLOAD;
        if (rem_r <= 32'd1) begin
          res.message_last = 1'b1;
          rem_nxt          = '0;
          phase_nxt        = PH_HEADER;
          idx_nxt          = '0;
          mism_nxt         = 1'b0;
        end else begin
          rem_nxt = rem_r - 32'd1;
        end
      end
      default: begin
        // fatal: pass through, discard
        res.byte_class = rpcfd_pkg::CLS_DISCARD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      idx_r   <= '0;
      mism_r  <= 1'b0;
      cl_r    <= '0;
      pl_r    <= '0;
      rem_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      mism_r  <= mism_nxt;
      cl_r    <= cl_nxt;
      pl_r    <= pl_nxt;
      rem_r   <= rem_nxt;
    end
  end

  `RPCFD_ASSERT_NEXT(a_err_goes_fatal, step && res.error_code != rpcfd_pkg::ERR_NONE, phase_r == PH_FATAL)
  `RPCFD_ASSERT_NEXT(a_fatal_sticks, phase_r == PH_FATAL, phase_r == PH_FATAL)
  `RPCFD_ASSERT_NEXT(a_msg_end_rearms, step && res.message_last, phase_r == PH_HEADER && idx_r == '0)
  `RPCFD_ASSERT_NOW(a_idx_in_header, 1'b1, idx_r <= rpcfd_pkg::HDR_LAST_IDX)
  `RPCFD_ASSERT_NOW(a_err_only_in_header, res.error_code != rpcfd_pkg::ERR_NONE, phase_r == PH_HEADER && idx_r == rpcfd_pkg::HDR_LAST_IDX)

endmodule

FILE: src/rpcfd_out_stage.sv
// ----------------------------------------------------------------------------
// rpcfd_out_stage
// Result register driving the master-side stream.
// ----------------------------------------------------------------------------
module rpcfd_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,       // stage free or being drained
  input  logic               ld_valid,
  input  rpcfd_pkg::result_t ld_res,
  output logic               out_tvalid,
  output logic [7:0]         out_tdata,  // [7:0] out_byte
  output logic [4:0]         out_tuser,  // [1:0] byte_class, [2] control_last, [4:3] error_code
  output logic               out_tlast   // message_last
);

  logic       v_r;
  logic [7:0] data_r;
  logic [4:0] user_r;
  logic       last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (load) begin
      v_r <= ld_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && ld_valid) begin
      data_r <= ld_res.out_byte;
      user_r <= {ld_res.error_code, ld_res.control_last, ld_res.byte_class};
      last_r <= ld_res.message_last;
    end
  end

  assign out_tvalid = v_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;

endmodule

FILE: src/rpc_frame_deframer.sv
// ----------------------------------------------------------------------------
// rpc_frame_deframer
// Byte-serial parser for magic-tagged, length-prefixed RPC frames.
// ----------------------------------------------------------------------------
// Takes one byte per transaction and returns one classified byte per
// transaction, in order. A frame is a 13-byte header ("RPC0.1" plus a zero
// byte, 16-bit little-endian control length, 32-bit little-endian payload
// length), then the control bytes, then the payload bytes. Throughput is one
// byte per clock unless the receiver stalls; bytes pass the input register,
// then the result register fed by the parser logic. A bad magic or a zero
// control length, seen on the last header byte, is reported once in
// error_code; after that every byte has class "discarded" until rst_n is asserted.
// ----------------------------------------------------------------------------
module rpc_frame_deframer (
  input  logic       clk,
  input  logic       rst_n,
  // slave side
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] data_byte
  // master side
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_byte
  output logic [4:0] out_tuser,   // [1:0] byte_class, [2] control_last, [4:3] error_code
  output logic       out_tlast    // message_last
);

  // Input register
  logic       in_v_r,    in_v_nxt;
  logic [7:0] in_byte_r;

  // Pipeline advances whenever the result register is empty or being taken
  logic               adv;
  logic               step;
  logic               in_acc;
  rpcfd_pkg::result_t res;

  assign adv       = !out_tvalid || out_tready;
  assign step      = adv && in_v_r;
  assign in_tready = !in_v_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_acc) begin
      in_v_nxt = 1'b1;
    end else if (adv) begin
      in_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_byte_r <= in_tdata;
    end
  end

  // Parse state and per-byte decision
  rpcfd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (in_byte_r),
    .res       (res)
  );

  // Result register
  rpcfd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (adv),
    .ld_valid   (in_v_r),
    .ld_res     (res),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for rpc_frame_deframer
// Drives byte transactions built as well-formed frames with random content,
// plus a directed start and a fatal-error tail. A scoreboard predicts every
// classified byte and checks each out transaction in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int IDLE_LIMIT   = 2000;  // cycles with no transaction on either side
  localparam int HOLD_CYCLES  = 64;    // long receiver hold-off
  localparam int RANDOM_BYTES = 360;

  localparam logic [7:0] MAGIC_STR [0:7] = '{8'h52, 8'h50, 8'h43, 8'h30,
                                             8'h2E, 8'h31, 8'h00, 8'h00};

  typedef enum logic [1:0] {
    PS_HEADER  = 2'd0,
    PS_CONTROL = 2'd1,
    PS_PAYLOAD = 2'd2,
    PS_DEAD    = 2'd3
  } parse_state_t;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the parser state, queue of expected bytes
  // --------------------------------------------------------------------------
  class deframer_scoreboard;
    parse_state_t          state;
    rpcfd_pkg::hdr_idx_t   hdr_pos;
    bit                    magic_bad;
    logic [15:0]           ctrl_len;
    logic [31:0]           pay_len;
    logic [31:0]           remaining;
    rpcfd_pkg::result_t    expected_q[$];
    int                    errors;
    int                    n_checked;

    function new();
      state     = PS_HEADER;
      hdr_pos   = '0;
      magic_bad = 1'b0;
      ctrl_len  = '0;
      pay_len   = '0;
      remaining = '0;
      errors    = 0;
      n_checked = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(input string msg);
      $display("mismatch at result %0d: %s", n_checked, msg);
      errors++;
    endtask

    // Work out the classified byte for one accepted input transaction
    function void note_input(input logic [7:0] b);
      rpcfd_pkg::result_t r;
      int                 i;
      r          = '0;
      r.out_byte = b;
      case (state)
        PS_HEADER: begin
          i            = int'(hdr_pos);
          r.byte_class = rpcfd_pkg::CLS_HEADER;
          if (i < rpcfd_pkg::MAGIC_LEN) begin
            if (b != MAGIC_STR[i & 7]) magic_bad = 1'b1;
          end else if (i < rpcfd_pkg::MAGIC_LEN + 2) begin
            ctrl_len[(i - rpcfd_pkg::MAGIC_LEN) * 8 +: 8] = b;
          end else if (i < rpcfd_pkg::HEADER_LEN) begin
            pay_len[(i - rpcfd_pkg::MAGIC_LEN - 2) * 8 +: 8] = b;
          end
          if (i + 1 >= rpcfd_pkg::HEADER_LEN) begin
            // bad magic wins over a zero control length
            if (magic_bad) begin
              r.error_code = rpcfd_pkg::ERR_BAD_MAGIC;
              state        = PS_DEAD;
            end else if (ctrl_len == 16'd0) begin
              r.error_code = rpcfd_pkg::ERR_ZERO_CTRL;
              state        = PS_DEAD;
            end else begin
              state     = PS_CONTROL;
              remaining = 32'(ctrl_len);
            end
            hdr_pos   = '0;
            magic_bad = 1'b0;
          end else begin
            hdr_pos = rpcfd_pkg::hdr_idx_t'(i + 1);
          end
        end
        PS_CONTROL: begin
          r.byte_class = rpcfd_pkg::CLS_CONTROL;
          if (remaining <= 32'd1) begin
            r.control_last = 1'b1;
            if (pay_len == 32'd0) begin
              r.message_last = 1'b1;
              remaining      = '0;
              state          = PS_HEADER;
              hdr_pos        = '0;
              magic_bad      = 1'b0;
            end else begin
              remaining = pay_len;
              state     = PS_PAYLOAD;
            end
          end else begin
            remaining--;
          end
        end
        PS_PAYLOAD: begin
          r.byte_class = rpcfd_pkg::CLS_PAYLOAD;
          if (remaining <= 32'd1) begin
            r.message_last = 1'b1;
            remaining      = '0;
            state          = PS_HEADER;
            hdr_pos        = '0;
            magic_bad      = 1'b0;
          end else begin
            remaining--;
          end
        end
        default: r.byte_class = rpcfd_pkg::CLS_DISCARD;
      endcase
      expected_q.push_back(r);
    endfunction

    // Compare one out transaction with the oldest expectation
    task check_result(input rpcfd_pkg::result_t got);
      rpcfd_pkg::result_t exp_r;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected byte %02h", got.out_byte));
      end else begin
        exp_r = expected_q.pop_front();
        if (got.out_byte != exp_r.out_byte)
          report($sformatf("out_byte %02h, want %02h", got.out_byte, exp_r.out_byte));
        if (got.byte_class != exp_r.byte_class)
          report($sformatf("byte_class %0d, want %0d", got.byte_class, exp_r.byte_class));
        if (got.control_last != exp_r.control_last)
          report($sformatf("control_last %0b, want %0b", got.control_last,
                           exp_r.control_last));
        if (got.message_last != exp_r.message_last)
          report($sformatf("message_last %0b, want %0b", got.message_last,
                           exp_r.message_last));
        if (got.error_code != exp_r.error_code)
          report($sformatf("error_code %0d, want %0d", got.error_code, exp_r.error_code));
      end
      n_checked++;
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT and signals
  // --------------------------------------------------------------------------
  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;     // [7:0] data_byte
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;    // [7:0] out_byte
  logic [4:0] out_tuser;    // [1:0] byte_class, [2] control_last, [4:3] error_code
  logic       out_tlast;    // message_last

  rpc_frame_deframer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  deframer_scoreboard sb;

  int src_idle_pct;    // chance per cycle that the sender idles
  int sink_stall_pct;  // chance per cycle that the receiver stalls
  bit hold_req;        // asks the receiver for one long hold-off
  int bytes_sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Sender tasks. Inputs move on the falling edge; acceptance is sampled on
  // the rising edge, before the DUT's own updates land.
  // --------------------------------------------------------------------------
  task send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    sb.note_input(b);
    bytes_sent++;
  endtask

  // Drop valid so nothing further is taken while the bench waits
  task src_quiet();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task set_idling(input int src_pct, input int sink_pct);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
  endtask

  // Header only: magic (optionally with one corrupted byte), then lengths
  task send_header(input logic [15:0] cl, input logic [31:0] pl, input int bad_pos);
    logic [7:0] b;
    for (int k = 0; k < rpcfd_pkg::MAGIC_LEN; k++) begin
      b = MAGIC_STR[k];
      if (k == bad_pos) b = b ^ 8'($urandom_range(1, 255));
      send_byte(b);
    end
    send_byte(cl[7:0]);
    send_byte(cl[15:8]);
    for (int k = 0; k < 4; k++) send_byte(pl[k*8 +: 8]);
  endtask

  // One frame: header, then body.
  // fill < 0 gives random body bytes, otherwise every body byte is fill.
  task send_frame(input logic [15:0] cl, input logic [31:0] pl,
                  input int bad_pos, input int fill);
    logic [7:0]      b;
    longint unsigned n;
    send_header(cl, pl, bad_pos);
    for (n = 0; n < longint'(cl) + longint'(pl); n++) begin
      if (fill < 0) b = 8'($urandom_range(0, 255));
      else          b = 8'(fill);
      send_byte(b);
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: ready moves on the falling edge; a hold-off is timed here
  // --------------------------------------------------------------------------
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_tready <= ($urandom_range(0, 99) < sink_stall_pct) ? 1'b0 : 1'b1;
    end
  end

  // Monitor: every out transaction goes to the scoreboard
  initial begin
    rpcfd_pkg::result_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.out_byte     = out_tdata;
        got.byte_class   = out_tuser[1:0];
        got.control_last = out_tuser[2];
        got.error_code   = out_tuser[4:3];
        got.message_last = out_tlast;
        sb.check_result(got);
      end
    end
  end

  // Watchdog: ends the run if neither side moves for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int          frame_no;
    int          kind;
    logic [15:0] cl;
    logic [31:0] pl;
    in_tvalid  = 1'b0;
    in_tdata   = 8'h00;
    rst_n      = 1'b0;
    hold_req   = 1'b0;
    bytes_sent = 0;
    set_idling(0, 0);
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: single control byte with no payload (message ends on the
    // control byte), single byte of each part, and all-ones / all-zeros bodies
    send_frame(16'd1, 32'd0, -1, 8'hFF);
    send_frame(16'd1, 32'd1, -1, 8'h00);
    send_frame(16'd2, 32'd3, -1, -1);

    // Random well-formed frames, rotating the idling pattern every 2 frames
    frame_no = 0;
    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      if (frame_no % 2 == 0) begin
        case ((frame_no / 2) % 4)
          0: set_idling(0, 0);
          1: set_idling(49, 0);
          2: set_idling(0, 49);
          default: set_idling(16, 16);
        endcase
      end
      // long receiver hold-off while the sender keeps offering
      if (frame_no == 1) hold_req = 1'b1;
      // sender pause until everything has drained
      if (frame_no == 7) begin
        src_quiet();
        wait_drained();
      end
      if ($urandom_range(0, 9) == 0) cl = 16'($urandom_range(256, 300));
      else                           cl = 16'($urandom_range(1, 12));
      if ($urandom_range(0, 3) == 0) pl = 32'd0;
      else                           pl = 32'($urandom_range(1, 20));
      send_frame(cl, pl, -1, -1);
      frame_no++;
    end

    // Fatal tail: only reset leaves the fatal state, so one error per run.
    // The failing header carries a full-range payload length; no body follows it.
    set_idling(16, 16);
    kind = $urandom_range(0, 2);
    case (kind)
      0: send_header(16'($urandom_range(1, 65535)), $urandom(),
                     $urandom_range(0, rpcfd_pkg::MAGIC_LEN - 1));
      1: send_header(16'd0, $urandom(), -1);
      default: send_header(16'd0, $urandom(),
                           $urandom_range(0, rpcfd_pkg::MAGIC_LEN - 1));
    endcase
    // a clean frame afterwards must come out discarded
    send_frame(16'd2, 32'd2, -1, -1);

    src_quiet();
    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
